@@ src/indexed_list_insert_erase_macros.svh @@
// assertion helpers used by the top rtl file
`ifndef INDEXED_LIST_INSERT_ERASE_MACROS_SVH
`define INDEXED_LIST_INSERT_ERASE_MACROS_SVH

// condition implies consequence in the same cycle
`define ILIE_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define ILIE_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ilie_pkg.sv @@
package ilie_pkg;

  // list geometry
  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // beat field widths
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_INSERT     = 3'd4,
    REQ_ERASE      = 3'd5,
    REQ_READ       = 3'd6
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // what every cell of the row does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_OPEN  = 2'd1,
    CELL_CLOSE = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e              op;
    logic [IDX_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] value;
  } cell_cmd_t;

endpackage

@@ src/indexed_list_insert_erase.sv @@
// Ordered list of up to 16 signed 32-bit entries held in a row of cells.
// Each input beat is one request: push back, push front, pop back, pop
// front, insert at a zero-based position, erase at a position or read at a
// position; insert and erase shift every later entry by one place in the
// same cycle, each cell taking its neighbor's word. Every request gives one
// output beat with status (ok, full, empty, out of range), read data (zero
// unless a read succeeds), the entry count after the request and the free
// slots left. The result is registered and a new beat is taken every cycle
// while the output side keeps up; the row shift and the read select of one
// entry happen in the cycle the beat is accepted. Rejected requests leave
// the list unchanged. Unused request codes return ok.
module indexed_list_insert_erase (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // req_type[2:0], position[6:3], value[38:7], zero fill
  input  logic [ilie_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // status[1:0], read_value[33:2], count[38:34], free_slots[43:39], zero fill
  output logic [ilie_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);
  import ilie_pkg::*;

  `include "indexed_list_insert_erase_macros.svh"

  localparam int unsigned OUT_USED_W = STATUS_W + VALUE_W + 2 * COUNT_W;

  logic                  in_fire;
  req_e                  req;
  logic [POS_W-1:0]      position;
  logic [VALUE_W-1:0]    value;
  logic                  full, empty;
  logic                  pos_gt_count, pos_ge_count;

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q;
  status_e               status_q, status_d;
  logic [VALUE_W-1:0]    read_q, read_d;
  logic [COUNT_W-1:0]    res_count_q, res_free_q;

  cell_cmd_t             cmd;
  cell_op_e              op_sel;
  logic [IDX_W-1:0]      pos_sel;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  // input beat fields
  assign req      = req_e'(s_axis_tdata_i[REQ_W-1:0]);
  assign position = s_axis_tdata_i[REQ_W +: POS_W];
  assign value    = s_axis_tdata_i[REQ_W + POS_W +: VALUE_W];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign full         = (count_q == CNT_W'(DEPTH));
  assign empty        = (count_q == '0);
  assign pos_gt_count = (CNT_W'(position) > count_q);
  assign pos_ge_count = (CNT_W'(position) >= count_q);

  // request decode
  always_comb begin
    status_d = ST_OK;
    read_d   = '0;
    count_d  = count_q;
    op_sel   = CELL_HOLD;
    pos_sel  = IDX_W'(position);
    case (req)
      REQ_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          op_sel  = CELL_OPEN;
          pos_sel = count_q[IDX_W-1:0];
          count_d = count_q + 1'b1;
        end
      end
      REQ_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          op_sel  = CELL_OPEN;
          pos_sel = '0;
          count_d = count_q + 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          op_sel  = CELL_CLOSE;
          pos_sel = '0;
          count_d = count_q - 1'b1;
        end
      end
      REQ_INSERT: begin
        if (pos_gt_count) begin
          status_d = ST_RANGE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          op_sel  = CELL_OPEN;
          count_d = count_q + 1'b1;
        end
      end
      REQ_ERASE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (pos_ge_count) begin
          status_d = ST_RANGE;
        end else begin
          op_sel  = CELL_CLOSE;
          count_d = count_q - 1'b1;
        end
      end
      REQ_READ: begin
        if (pos_ge_count) begin
          status_d = ST_RANGE;
        end else begin
          read_d = VALUE_W'($signed(cell_data[IDX_W'(position)]));
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  // command broadcast to the row, only on an accepted beat
  always_comb begin
    cmd.op    = in_fire ? op_sel : CELL_HOLD;
    cmd.pos   = pos_sel;
    cmd.value = value[DATA_WIDTH-1:0];
  end

  // row of cells, each wired to its neighbors
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (gi == 0) begin : g_first
      assign left_w = cell_data[gi];
    end else begin : g_left
      assign left_w = cell_data[gi-1];
    end
    if (gi == DEPTH - 1) begin : g_last
      assign right_w = cell_data[gi];
    end else begin : g_right
      assign right_w = cell_data[gi+1];
    end
    ilie_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(gi)),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[gi])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q <= count_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q    <= status_d;
      read_q      <= read_d;
      res_count_q <= COUNT_W'(count_d);
      res_free_q  <= COUNT_W'(CNT_W'(DEPTH) - count_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                            res_free_q, res_count_q, read_q, status_q};

  // checks
  `ILIE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "entry count above depth")
  `ILIE_ASSERT_NOW(a_count_free_sum, out_valid_q,
    (CNT_W + 1)'(res_count_q) + (CNT_W + 1)'(res_free_q) == (CNT_W + 1)'(DEPTH),
    "count and free slots disagree")
  `ILIE_ASSERT_NEXT(a_push_grows, in_fire && req == REQ_PUSH_BACK && !full,
    count_q == $past(count_q) + 1'b1, "push did not grow the list")
  `ILIE_ASSERT_NEXT(a_read_range, in_fire && req == REQ_READ && pos_ge_count,
    status_q == ST_RANGE && read_q == '0, "out of range read not flagged")

endmodule

@@ src/ilie_cell.sv @@
module ilie_cell (
  input  logic                            clk_i,
  input  logic [ilie_pkg::IDX_W-1:0]      idx_i,
  input  ilie_pkg::cell_cmd_t             cmd_i,
  input  logic [ilie_pkg::DATA_WIDTH-1:0] left_i,
  input  logic [ilie_pkg::DATA_WIDTH-1:0] right_i,
  output logic [ilie_pkg::DATA_WIDTH-1:0] data_o
);
  import ilie_pkg::*;

  logic [DATA_WIDTH-1:0] data_q, data_d;

  // open a gap: load at the position, take the lower neighbor above it
  // close a gap: take the upper neighbor from the position up
  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      CELL_OPEN: begin
        if (idx_i == cmd_i.pos) begin
          data_d = cmd_i.value;
        end else if (idx_i > cmd_i.pos) begin
          data_d = left_i;
        end
      end
      CELL_CLOSE: begin
        if (idx_i >= cmd_i.pos) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import ilie_pkg::*;

  // request code that the block treats as a no-op
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

  typedef enum int unsigned {
    MIX_ANY,
    MIX_GROW,
    MIX_SHRINK
  } mix_e;

  typedef struct packed {
    status_e              status;
    logic [VALUE_W-1:0]   read_value;
    logic [COUNT_W-1:0]   count;
    logic [COUNT_W-1:0]   free_slots;
  } list_result_t;

  // shadow list: predicts the response of every accepted request
  class list_scoreboard;
    logic [DATA_WIDTH-1:0] slot_q [DEPTH];
    int unsigned           fill;
    list_result_t          expect_q [$];
    int unsigned           errors;
    int unsigned           op_seen [8];
    int unsigned           status_seen [4];

    function new();
      fill   = 0;
      errors = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void note_request(input logic [IN_TDATA_W-1:0] beat);
      logic [REQ_W-1:0]   op;
      logic [POS_W-1:0]   pos;
      logic [VALUE_W-1:0] val;
      list_result_t       res;
      int unsigned        i;
      op  = beat[2:0];
      pos = beat[6:3];
      val = beat[38:7];
      res.status     = ST_OK;
      res.read_value = '0;
      op_seen[op]++;
      case (op)
        REQ_PUSH_BACK: begin
          if (fill == DEPTH) begin
            res.status = ST_FULL;
          end else begin
            slot_q[fill] = val;
            fill++;
          end
        end
        REQ_PUSH_FRONT: begin
          if (fill == DEPTH) begin
            res.status = ST_FULL;
          end else begin
            for (i = fill; i > 0; i--) slot_q[i] = slot_q[i-1];
            slot_q[0] = val;
            fill++;
          end
        end
        REQ_POP_BACK: begin
          if (fill == 0) res.status = ST_EMPTY;
          else fill--;
        end
        REQ_POP_FRONT: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
          end else begin
            for (i = 0; i + 1 < fill; i++) slot_q[i] = slot_q[i+1];
            fill--;
          end
        end
        REQ_INSERT: begin
          // range is judged before fullness
          if (pos > fill) begin
            res.status = ST_RANGE;
          end else if (fill == DEPTH) begin
            res.status = ST_FULL;
          end else begin
            for (i = fill; i > pos; i--) slot_q[i] = slot_q[i-1];
            slot_q[pos] = val;
            fill++;
          end
        end
        REQ_ERASE: begin
          if (fill == 0) begin
            res.status = ST_EMPTY;
          end else if (pos >= fill) begin
            res.status = ST_RANGE;
          end else begin
            for (i = pos; i + 1 < fill; i++) slot_q[i] = slot_q[i+1];
            fill--;
          end
        end
        REQ_READ: begin
          if (pos >= fill) res.status = ST_RANGE;
          else res.read_value = slot_q[pos];
        end
        default: ;
      endcase
      res.count      = COUNT_W'(fill);
      res.free_slots = COUNT_W'(DEPTH - fill);
      expect_q = {expect_q, res};
    endfunction

    function void check_result(input logic [OUT_TDATA_W-1:0] beat);
      list_result_t want;
      if (expect_q.size() == 0) begin
        $error("response beat %h with no request pending", beat);
        errors++;
        return;
      end
      want = expect_q[0];
      expect_q.delete(0);
      status_seen[beat[1:0]]++;
      if (beat[1:0] != want.status) begin
        $error("status: expected %0d, got %0d", want.status, beat[1:0]);
        errors++;
      end
      if (beat[33:2] != want.read_value) begin
        $error("read_value: expected %0d, got %0d",
               $signed(want.read_value), $signed(beat[33:2]));
        errors++;
      end
      if (beat[38:34] != want.count) begin
        $error("count: expected %0d, got %0d", want.count, beat[38:34]);
        errors++;
      end
      if (beat[43:39] != want.free_slots) begin
        $error("free_slots: expected %0d, got %0d", want.free_slots, beat[43:39]);
        errors++;
      end
      if (beat[47:44] != '0) begin
        $error("fill bits: expected 0, got %h", beat[47:44]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_n;
  logic                   s_valid;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_data;
  logic                   m_valid;
  logic                   m_ready;
  logic [OUT_TDATA_W-1:0] m_data;

  int unsigned    src_idle_pct;
  int unsigned    sink_idle_pct;
  logic           sink_hold;
  int unsigned    results_seen = 0;
  list_scoreboard sb = new();

  indexed_list_insert_erase dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // offer one request beat, with an occasional gap first
  task automatic send_req(input logic [REQ_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic [VALUE_W-1:0] val);
    logic [IN_TDATA_W-1:0] beat;
    beat = {1'b0, val, pos, op};
    if ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= beat;
    // ready is stable between the falling and the next rising edge
    @(negedge clk_i);
    while (!s_ready) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_request(beat);
  endtask

  // random requests biased toward growing, shrinking or neither
  task automatic run_phase(input mix_e mix, input int unsigned n);
    logic [REQ_W-1:0]   op;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    int unsigned        roll;
    int unsigned        top;
    repeat (n) begin
      roll = $urandom_range(99);
      case (mix)
        MIX_GROW: begin
          if (roll < 30) op = REQ_PUSH_BACK;
          else if (roll < 55) op = REQ_PUSH_FRONT;
          else if (roll < 85) op = REQ_INSERT;
          else if (roll < 95) op = REQ_READ;
          else op = REQ_W'($urandom_range(7));
        end
        MIX_SHRINK: begin
          if (roll < 25) op = REQ_POP_BACK;
          else if (roll < 50) op = REQ_POP_FRONT;
          else if (roll < 85) op = REQ_ERASE;
          else if (roll < 95) op = REQ_READ;
          else op = REQ_W'($urandom_range(7));
        end
        default: op = REQ_W'($urandom_range(7));
      endcase
      // positions mostly near the live part of the list
      top = (sb.fill > 15) ? 15 : sb.fill;
      if ($urandom_range(3) != 0) pos = POS_W'($urandom_range(top));
      else pos = POS_W'($urandom_range(15));
      case ($urandom_range(9))
        0: val = 32'h7FFF_FFFF;
        1: val = 32'h8000_0000;
        2: val = '0;
        3: val = '1;
        default: val = $urandom();
      endcase
      send_req(op, pos, val);
    end
  endtask

  // response side: sample at the falling edge, score at the rising edge
  initial begin : sink
    logic                   got;
    logic [OUT_TDATA_W-1:0] beat;
    m_ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      got  = m_valid && m_ready;
      beat = m_data;
      @(posedge clk_i);
      if (got) begin
        sb.check_result(beat);
        results_seen++;
      end
      m_ready <= rst_n && !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // long output stall so the block backs up into its input
  initial begin : sink_backpressure
    sink_hold = 1'b0;
    wait (results_seen >= 400);
    @(negedge clk_i);
    sink_hold = 1'b1;
    repeat (80) @(negedge clk_i);
    sink_hold = 1'b0;
  end

  // hard stop
  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned round;
    s_valid <= 1'b0;
    s_data  <= '0;
    rst_n   <= 1'b0;
    src_idle_pct  = 10;
    sink_idle_pct = 10;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // empty list: every rejecting path
    send_req(REQ_READ,       4'd0,  '0);
    send_req(REQ_POP_BACK,   4'd0,  '0);
    send_req(REQ_POP_FRONT,  4'd0,  '0);
    send_req(REQ_ERASE,      4'd0,  '0);
    send_req(REQ_UNUSED,     4'd9,  32'hDEAD_BEEF);
    send_req(REQ_INSERT,     4'd1,  32'h1111_1111);
    // build a short list with extreme words
    send_req(REQ_INSERT,     4'd0,  32'h8000_0000);
    send_req(REQ_PUSH_BACK,  4'd15, 32'h7FFF_FFFF);
    send_req(REQ_PUSH_FRONT, 4'd0,  32'hFFFF_FFFF);
    send_req(REQ_INSERT,     4'd3,  32'h0000_0000);
    send_req(REQ_INSERT,     4'd15, 32'h5555_5555);
    send_req(REQ_INSERT,     4'd2,  32'h1234_5678);
    for (int p = 0; p < 6; p++) send_req(REQ_READ, POS_W'(p), '0);
    send_req(REQ_ERASE,      4'd5,  '0);
    send_req(REQ_ERASE,      4'd2,  '0);
    send_req(REQ_ERASE,      4'd0,  '0);
    send_req(REQ_POP_FRONT,  4'd0,  '0);
    send_req(REQ_POP_BACK,   4'd0,  '0);
    send_req(REQ_ERASE,      4'd0,  '0);

    // random rounds: fill past full, drain past empty, then anything
    for (round = 0; round < 14; round++) begin
      if (round == 2) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (round == 4) begin
        src_idle_pct  = 10;
        sink_idle_pct = 10;
      end
      run_phase(MIX_GROW, 40);
      run_phase(MIX_SHRINK, 40);
      run_phase(MIX_ANY, 35);
    end
    s_valid <= 1'b0;

    // drain, then allow stray beats to show up
    while (sb.expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $write("requests: %0d back pushes, %0d front pushes, %0d back pops, ",
           sb.op_seen[0], sb.op_seen[1], sb.op_seen[2]);
    $display("%0d front pops, %0d inserts, %0d erases, %0d reads, %0d unused",
             sb.op_seen[3], sb.op_seen[4], sb.op_seen[5], sb.op_seen[6],
             sb.op_seen[7]);
    $display("responses: %0d ok, %0d full, %0d empty, %0d out of range",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/ilie_pkg.sv
src/ilie_cell.sv
src/indexed_list_insert_erase.sv
tb/tb.sv
